[src/pte_pkg.sv]
// Package for the eased pan/tilt pointer: widths, constants, CORDIC table.
// No dependencies.
package pte_pkg;
  localparam int AngleWidth  = 16;
  localparam int CordicSteps = 14;
  localparam int DivWidth    = 26;
  localparam int ZWidth      = 24;
  localparam int XyWidth     = 32;

  typedef logic signed [AngleWidth-1:0] angle_t;

  typedef enum logic [1:0] {
    CmdTick = 2'd0,
    CmdMove = 2'd1,
    CmdSet  = 2'd2,
    CmdNone = 2'd3
  } cmd_e;

  localparam logic signed [AngleWidth+1:0] FullTurn    = 18'sd23040;
  localparam logic signed [AngleWidth+1:0] QuarterTurn = 18'sd5760;
  localparam logic signed [XyWidth-1:0]    CordicGain  = 32'sd163008219;
  localparam logic signed [15:0]           Q14One      = 16'sd16384;

  function automatic logic [ZWidth-1:0] atan_lut(input logic [4:0] i);
    logic [ZWidth-1:0] r;
    case (i)
      5'd0:  r = 24'd2949120;
      5'd1:  r = 24'd1740967;
      5'd2:  r = 24'd919879;
      5'd3:  r = 24'd466945;
      5'd4:  r = 24'd234379;
      5'd5:  r = 24'd117304;
      5'd6:  r = 24'd58666;
      5'd7:  r = 24'd29335;
      5'd8:  r = 24'd14668;
      5'd9:  r = 24'd7334;
      5'd10: r = 24'd3667;
      5'd11: r = 24'd1833;
      5'd12: r = 24'd917;
      5'd13: r = 24'd458;
      5'd14: r = 24'd229;
      5'd15: r = 24'd115;
      5'd16: r = 24'd57;
      5'd17: r = 24'd29;
      5'd18: r = 24'd14;
      5'd19: r = 24'd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;
endpackage

[src/pte_stream_if.sv]
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
interface pte_stream_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/pte_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pte_pkg.
module pte_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pte_pkg::DivWidth-1:0]  num_i,
  input  logic [pte_pkg::DivWidth-1:0]  den_i,
  output logic                          done_o,
  output logic [pte_pkg::DivWidth-1:0]  quo_o
);
  localparam int W = pte_pkg::DivWidth;
  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [4:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [W:0]   trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[W-1]};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; cnt_d = 5'(W - 1); busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = W'(trial - {1'b0, den_q});
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

[src/pte_cordic.sv]
// Rotation-mode CORDIC, one micro-rotation per cycle, gives cos/sin in Q2.14.
// Depends on pte_pkg.
module pte_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pte_pkg::angle_t     angle_i,
  output logic                done_o,
  output logic signed [15:0]  cos_o,
  output logic signed [15:0]  sin_o
);
  localparam int ZW = pte_pkg::ZWidth;
  localparam int XW = pte_pkg::XyWidth;
  typedef enum logic [1:0] {Idle, Reduce, Rotate, Finish} state_e;

  state_e state_q;
  logic signed [17:0]   r_q;
  logic [1:0]           quad_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [4:0]           i_q;
  logic                 done_q;
  logic signed [15:0]   cos_q, sin_q;
  logic signed [XW-1:0] xs, ys, xr, yr;
  logic signed [15:0]   c, s;

  function automatic logic signed [15:0] clampq(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v + XW'(8192)) >>> 14;
    if (t > XW'(16384)) return pte_pkg::Q14One;
    if (t < -XW'(16384)) return -pte_pkg::Q14One;
    return t[15:0];
  endfunction

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign c  = clampq(x_q);
  assign s  = clampq(y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; done_q <= 1'b0; i_q <= '0; quad_q <= '0;
      r_q <= '0; x_q <= '0; y_q <= '0; z_q <= '0; cos_q <= '0; sin_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        Idle: if (start_i) begin
          // add two turns to a negative angle, then walk down quadrants
          r_q    <= (18'(angle_i) < 0) ? 18'(angle_i) + 18'(2 * pte_pkg::FullTurn)
                                       : 18'(angle_i);
          quad_q <= '0;
          state_q <= Reduce;
        end
        Reduce: begin
          if (r_q >= pte_pkg::QuarterTurn) begin
            r_q <= r_q - pte_pkg::QuarterTurn; quad_q <= quad_q + 2'd1;
          end else begin
            x_q <= pte_pkg::CordicGain; y_q <= '0;
            z_q <= ZW'(r_q) <<< 10; i_q <= '0;
            state_q <= Rotate;
          end
        end
        Rotate: begin
          if (!z_q[ZW-1]) begin
            x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - pte_pkg::atan_lut(i_q);
          end else begin
            x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + pte_pkg::atan_lut(i_q);
          end
          i_q <= i_q + 5'd1;
          if (i_q == 5'(pte_pkg::CordicSteps - 1)) state_q <= Finish;
        end
        Finish: begin
          // map back by quadrant
          case (quad_q)
            2'd0:    begin cos_q <= c;  sin_q <= s;  end
            2'd1:    begin cos_q <= -s; sin_q <= c;  end
            2'd2:    begin cos_q <= -c; sin_q <= -s; end
            default: begin cos_q <= s;  sin_q <= -c; end
          endcase
          done_q <= 1'b1; state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
endmodule

[src/pan_tilt_eased_pointer.sv]
// Eased pan/tilt pointer: sequencer around a shared divider and shared CORDIC.
// Depends on pte_pkg, pte_stream_if, pte_divider, pte_cordic.
// A move or unused command goes straight to Output. Throughput: one beat at a time;
// in_s.ready is low from accept to result taken. Set and tick wait on the CORDIC
// (longer by quadrant folding); tick also waits on the serial divider for each
// easing axis, but not for a snapping axis.
// Reset clears angles, vector and speed (speed resets to 10).
module pan_tilt_eased_pointer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  pte_stream_if.sink        in_s,
  pte_stream_if.source      out_s
);
  localparam int DW = pte_pkg::DivWidth;
  typedef enum logic [3:0] {
    Idle, DivPan, WaitPan, DivTilt, WaitTilt, TrigPan, WaitTp, TrigTilt, WaitTt,
    MulX, MulY, Output
  } state_e;

  state_e state_q;
  logic [7:0] speed_q;
  pte_pkg::angle_t cur_p_q, cur_t_q, tgt_p_q, tgt_t_q;
  logic signed [15:0] dx_q, dy_q, dz_q, cp_q, sp_q;
  logic [1:0] cmd;
  pte_pkg::angle_t pin, tin;
  logic out_v_q;
  logic neg_q;

  // divider hookup
  logic div_start, div_done;
  logic [DW-1:0] div_num, div_den, div_quo;
  logic signed [DW-1:0] num_s;
  logic signed [16:0] diff;
  pte_pkg::angle_t e_cur, e_tgt;
  logic snap;

  // cordic hookup
  pte_pkg::unit_ctl_t cctl;
  pte_pkg::angle_t c_ang;
  logic c_done;
  logic signed [15:0] c_cos, c_sin;
  logic signed [31:0] prod;
  logic signed [31:0] prod_r;

  assign cmd = in_s.data[33:32];
  assign pin = in_s.data[31:16];
  assign tin = in_s.data[15:0];

  assign e_cur = (state_q == DivPan || state_q == WaitPan) ? cur_p_q : cur_t_q;
  assign e_tgt = (state_q == DivPan || state_q == WaitPan) ? tgt_p_q : tgt_t_q;
  assign diff  = 17'(e_tgt) - 17'(e_cur);
  assign snap  = (diff > -17'sd64) && (diff < 17'sd64);
  assign num_s = DW'(e_tgt) + DW'(e_cur) * $signed({1'b0, speed_q});
  // rounded magnitude: (2|n| + d) / 2d with d = speed + 1
  assign div_num = DW'({(num_s[DW-1] ? -num_s : num_s), 1'b0}) + DW'(speed_q) + DW'(1);
  assign div_den = DW'({1'b0, speed_q, 1'b0}) + DW'(2);
  assign div_start = (state_q == DivPan || state_q == DivTilt) && !snap;

  pte_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign cctl.start = (state_q == TrigPan) || (state_q == TrigTilt);
  assign cctl.busy  = (state_q == WaitTp) || (state_q == WaitTt);
  assign c_ang = (state_q == TrigPan) ? cur_p_q : cur_t_q;

  pte_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cctl.start), .angle_i(c_ang),
    .done_o(c_done), .cos_o(c_cos), .sin_o(c_sin)
  );

  assign prod   = 32'(dz_q) * 32'((state_q == MulX) ? sp_q : cp_q);
  assign prod_r = (prod + 32'sd8192) >>> 14;

  assign in_s.ready = (state_q == Idle) && !out_v_q;
  assign out_s.valid = out_v_q;
  assign out_s.data  = {cur_p_q, cur_t_q, dx_q, dy_q, dz_q};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; speed_q <= 8'd10; out_v_q <= 1'b0; neg_q <= 1'b0;
      cur_p_q <= '0; cur_t_q <= '0; tgt_p_q <= '0; tgt_t_q <= '0;
      dx_q <= '0; dy_q <= '0; dz_q <= '0; cp_q <= '0; sp_q <= '0;
    end else begin
      if (cfg_we_i) speed_q <= cfg_wdata_i;
      if (out_v_q && out_s.ready) out_v_q <= 1'b0;
      case (state_q)
        Idle: if (in_s.valid && in_s.ready) begin
          case (pte_pkg::cmd_e'(cmd))
            pte_pkg::CmdTick: state_q <= DivPan;
            pte_pkg::CmdMove: begin
              tgt_p_q <= pin; tgt_t_q <= tin; state_q <= Output;
            end
            pte_pkg::CmdSet: begin
              cur_p_q <= pin; tgt_p_q <= pin; cur_t_q <= tin; tgt_t_q <= tin;
              state_q <= TrigPan;
            end
            default: state_q <= Output;
          endcase
        end
        DivPan: begin
          neg_q <= num_s[DW-1];
          if (snap) begin cur_p_q <= tgt_p_q; state_q <= DivTilt; end
          else state_q <= WaitPan;
        end
        WaitPan: if (div_done) begin
          cur_p_q <= neg_q ? -div_quo[15:0] : div_quo[15:0]; state_q <= DivTilt;
        end
        DivTilt: begin
          neg_q <= num_s[DW-1];
          if (snap) begin cur_t_q <= tgt_t_q; state_q <= TrigPan; end
          else state_q <= WaitTilt;
        end
        WaitTilt: if (div_done) begin
          cur_t_q <= neg_q ? -div_quo[15:0] : div_quo[15:0]; state_q <= TrigPan;
        end
        TrigPan: state_q <= WaitTp;
        WaitTp: if (c_done) begin
          cp_q <= c_cos; sp_q <= c_sin; state_q <= TrigTilt;
        end
        TrigTilt: state_q <= WaitTt;
        WaitTt: if (c_done) begin
          // hold cos t in dz for the products, sin t goes out later
          dz_q <= c_cos; dy_q <= c_sin; state_q <= MulX;
        end
        MulX: begin dx_q <= prod_r[15:0]; state_q <= MulY; end
        MulY: begin
          dz_q <= dy_q; dy_q <= prod_r[15:0]; state_q <= Output;
        end
        Output: begin out_v_q <= 1'b1; state_q <= Idle; end
        default: state_q <= Idle;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != Idle) |-> !in_s.ready) else $error("ready while busy");
  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q == Output)) else $error("stray result");
  a_cordic_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cctl.start |=> cctl.busy) else $error("cordic start lost");
`endif
endmodule
